// ===== rtl/point_segment_distance_squared_defines.svh =====
// Assertion macros for the point to segment distance block.
// Used by the port checker; no other dependencies.
`ifndef POINT_SEGMENT_DISTANCE_SQUARED_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_SQUARED_DEFINES_SVH
// implication checked each clock, reset disables
`define PSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/psd_pkg.sv =====
// Package for the point to segment distance block: widths, codes, types, and the fold_q16 saturating helper.
// No dependencies.
`default_nettype none
package psd_pkg;
   localparam int CoordW = 32;
   localparam int DistW = 48;
   localparam int QueueDepth = 4;
   localparam int CsrIdxW = 3;

   typedef enum logic [1:0] {
      CASE_SHORT = 2'd0,
      CASE_FLAT = 2'd1,
      CASE_INSIDE = 2'd2,
      CASE_OUTSIDE = 2'd3
   } case_type;

   typedef enum logic [CsrIdxW-1:0] {
      REG_MIN_LEN = 3'd0,
      REG_Z_TOL = 3'd1,
      REG_T_LOW = 3'd2,
      REG_T_UP = 3'd3,
      REG_MISS = 3'd4
   } reg_type;

   typedef struct packed {
      logic [31:0] min_length_sq;
      logic [30:0] z_tolerance;
      logic signed [31:0] t_lower;
      logic signed [31:0] t_upper;
      logic [47:0] miss_value;
   } cfg_type;

   // front -> back queue entry
   typedef struct packed {
      logic signed [32:0] v0, v1, v2;
      logic signed [32:0] d0, d1, d2;
      logic project;
      case_type code;
   } job_type;

   function automatic logic [47:0] fold_q16(input logic [99:0] s);
      logic [47:0] r;
      if (|s[99:64]) r = '1;
      else r = s[63:16];
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/psd_front.sv =====
// Front: differences, length test and flat-z test for each item.
// Uses psd_pkg.
`default_nettype none
module psd_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic [287:0] in_data,
   input wire psd_pkg::cfg_type cfg,
   output logic out_valid,
   input wire logic out_ready,
   output psd_pkg::job_type out_job
);
   import psd_pkg::*;
   logic s1_valid_ff, s1_valid_in;
   logic signed [32:0] v_ff [3], d_ff [3];
   logic [65:0] sq_ff [3];
   logic s2_valid_ff, s2_valid_in;
   job_type job_ff, job_in;
   logic adv1, adv2;
   logic [67:0] lensq;
   logic signed [32:0] ntol, ptol;

   assign adv2 = !s2_valid_ff || out_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_ready = adv1;
   assign s1_valid_in = adv1 ? in_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [32:0] p, s, e, dd;
            p = 33'(signed'(in_data[32*i +: 32]));
            s = 33'(signed'(in_data[32*(3+i) +: 32]));
            e = 33'(signed'(in_data[32*(6+i) +: 32]));
            dd = e - s;
            v_ff[i] <= p - s;
            d_ff[i] <= dd;
            sq_ff[i] <= 66'(dd * dd);
         end
      end
   end

   assign lensq = 68'(sq_ff[0]) + 68'(sq_ff[1]) + 68'(sq_ff[2]);
   assign ptol = 33'(cfg.z_tolerance);
   assign ntol = -ptol;

   always_comb begin
      job_in.v0 = v_ff[0]; job_in.v1 = v_ff[1]; job_in.v2 = v_ff[2];
      job_in.d0 = d_ff[0]; job_in.d1 = d_ff[1]; job_in.d2 = d_ff[2];
      job_in.project = 1'b0;
      if (lensq < {20'd0, cfg.min_length_sq, 16'd0}) job_in.code = CASE_SHORT;
      else if (d_ff[2] > ntol && d_ff[2] < ptol) job_in.code = CASE_FLAT;
      else if (lensq == '0) job_in.code = CASE_SHORT;
      else begin
         job_in.code = CASE_INSIDE;
         job_in.project = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end
   assign out_valid = s2_valid_ff;
   assign out_job = job_ff;
endmodule
`default_nettype wire

// ===== rtl/psd_queue.sv =====
// Small FIFO carrying jobs from the front to the back.
// Uses psd_pkg.
`default_nettype none
module psd_queue #(
   parameter int Depth = psd_pkg::QueueDepth
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire psd_pkg::job_type in_job,
   output logic out_valid,
   input wire logic out_ready,
   output psd_pkg::job_type out_job
);
   import psd_pkg::*;
   localparam int AW = $clog2(Depth);
   job_type mem [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != (AW+1)'(Depth);
   assign out_valid = cnt_ff != '0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_job = mem[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= in_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule
`default_nettype wire

// ===== rtl/psd_back.sv =====
// Back: dot product, pipelined restoring divide for t, projection, distance.
// Uses psd_pkg. One item per cycle; fixed latency pipeline with global stall.
`default_nettype none
module psd_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire psd_pkg::job_type in_job,
   input wire psd_pkg::cfg_type cfg,
   output logic out_valid,
   input wire logic out_ready,
   output logic [47:0] out_dist,
   output psd_pkg::case_type out_code
);
   import psd_pkg::*;
   // divide: 48 quotient bits (saturate at 2^31), 4 bits per stage
   localparam int QW = 48;
   localparam int BPS = 4;
   localparam int NDS = QW / BPS;
   localparam int NW = 116;   // dot magnitude << 16 fits here
   localparam int DW = 68;
   localparam int NST = 4 + NDS + 4;

   typedef struct packed {
      logic signed [32:0] v0, v1, v2, d0, d1, d2;
      logic project;
      case_type code;
      logic neg;
      logic [NW-1:0] num;
      logic [DW-1:0] den;
      logic [DW:0] rem;
      logic [QW-1:0] q;
      logic signed [32:0] t;
      logic signed [33:0] f0, f1, f2;
      logic big;
      logic [99:0] ss;
   } pl_type;

   logic adv;
   logic [NST-1:0] vld_ff;
   pl_type st_ff [NST];
   pl_type st_in [NST];
   logic [65:0] pr_ff [3], sq_ff [3];

   assign adv = !vld_ff[NST-1] || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NST-2:0], in_valid};
   end

   // stage 0: capture, products for dot and length
   always_comb begin
      st_in[0] = '0;
      st_in[0].v0 = in_job.v0; st_in[0].v1 = in_job.v1; st_in[0].v2 = in_job.v2;
      st_in[0].d0 = in_job.d0; st_in[0].d1 = in_job.d1; st_in[0].d2 = in_job.d2;
      st_in[0].project = in_job.project;
      st_in[0].code = in_job.code;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [32:0] va [3], da [3];
         va[0] = in_job.v0; va[1] = in_job.v1; va[2] = in_job.v2;
         da[0] = in_job.d0; da[1] = in_job.d1; da[2] = in_job.d2;
         for (int i = 0; i < 3; i++) begin
            pr_ff[i] <= 66'(signed'(va[i]) * signed'(da[i]));
            sq_ff[i] <= 66'(signed'(da[i]) * signed'(da[i]));
         end
      end
   end
   // stage 1: dot sum, length sum
   always_comb begin
      logic signed [67:0] dot;
      st_in[1] = st_ff[0];
      dot = 68'(signed'(pr_ff[0])) + 68'(signed'(pr_ff[1])) + 68'(signed'(pr_ff[2]));
      st_in[1].neg = dot[67];
      st_in[1].num = NW'(dot[67] ? 68'(-dot) : dot) << 16;
      st_in[1].den = 68'(sq_ff[0]) + 68'(sq_ff[1]) + 68'(sq_ff[2]);
   end
   // stages 2,3: pass (balance)
   always_comb st_in[2] = st_ff[1];
   always_comb st_in[3] = st_ff[2];
   // divide stages: quotient bits QW-1 .. 0; numerator bits above QW+... treated
   // by starting remainder at num >> QW (prefix); if prefix >= den quotient huge
   always_comb begin
      logic [DW:0] r;
      logic [QW-1:0] q;
      logic sat;
      st_in[4] = st_ff[3];
      // prefix num[NW-1:QW] (68 bits) compared to den: if >= den, q >= 2^48
      sat = st_ff[3].num[NW-1:QW] >= st_ff[3].den;
      r = sat ? '0 : {1'b0, st_ff[3].num[NW-1:QW]};
      q = sat ? '1 : '0;
      st_in[4].rem = r;
      st_in[4].q = q;
      st_in[4].project = st_ff[3].project;
      st_in[4].neg = st_ff[3].neg | 1'b0;
      st_in[4].ss = {99'd0, sat};
   end
   for (genvar g = 0; g < NDS; g++) begin : g_div
      always_comb begin
         logic [DW:0] r;
         logic [QW-1:0] q;
         int bi;
         st_in[5+g] = st_ff[4+g];
         r = st_ff[4+g].rem;
         q = st_ff[4+g].q;
         for (int k = 0; k < BPS; k++) begin
            bi = QW - 1 - (g*BPS + k);
            r = {r[DW-1:0], st_ff[4+g].num[bi]};
            if (st_ff[4+g].ss[0]) begin
               r = '0;
            end else if (r >= {1'b0, st_ff[4+g].den}) begin
               r = r - {1'b0, st_ff[4+g].den};
               q[bi] = 1'b1;
            end
         end
         st_in[5+g].rem = r;
         st_in[5+g].q = q;
      end
   end
   // form t, window test, projection products
   localparam int SA = 4 + NDS;
   always_comb begin
      logic [32:0] tm;
      logic signed [32:0] t;
      st_in[SA+1] = st_ff[SA];
      tm = (|st_ff[SA].q[QW-1:31]) ? 33'h080000000 : {1'b0, st_ff[SA].q[31:0]};
      if (st_ff[SA].neg) t = -signed'(tm);
      else t = tm[31] ? 33'sh07FFFFFFF : signed'(tm);
      st_in[SA+1].t = t;
      if (st_ff[SA].project) begin
         if (t > 33'(cfg.t_lower) && t < 33'(cfg.t_upper)) st_in[SA+1].code = CASE_INSIDE;
         else st_in[SA+1].code = CASE_OUTSIDE;
      end
   end
   logic signed [65:0] dt_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         dt_ff[0] <= 66'(st_in[SA+1].d0 * st_in[SA+1].t);
         dt_ff[1] <= 66'(st_in[SA+1].d1 * st_in[SA+1].t);
         dt_ff[2] <= 66'(st_in[SA+1].d2 * st_in[SA+1].t);
      end
   end
   // diff = trunc(d*t/2^16) - v for the inside case, else v
   // any |diff| >= 2^32 already saturates the distance
   always_comb begin
      logic signed [65:0] a [3];
      logic signed [65:0] w [3];
      logic signed [32:0] vv [3];
      vv[0] = st_ff[SA+1].v0; vv[1] = st_ff[SA+1].v1; vv[2] = st_ff[SA+1].v2;
      st_in[SA+2] = st_ff[SA+1];
      st_in[SA+2].big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         a[i] = dt_ff[i];
         if (a[i] < 0) a[i] = -((-a[i]) >>> 16);
         else a[i] = a[i] >>> 16;
         if (st_ff[SA+1].code == CASE_INSIDE) w[i] = a[i] - 66'(vv[i]);
         else w[i] = 66'(vv[i]);
         if (w[i] > 66'sh0FFFFFFFF || w[i] < -66'sh0FFFFFFFF) st_in[SA+2].big = 1'b1;
      end
      st_in[SA+2].f0 = 34'(w[0]);
      st_in[SA+2].f1 = 34'(w[1]);
      st_in[SA+2].f2 = 34'(w[2]);
   end
   logic [67:0] fs_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         fs_ff[0] <= 68'(st_in[SA+2].f0 * st_in[SA+2].f0);
         fs_ff[1] <= 68'(st_in[SA+2].f1 * st_in[SA+2].f1);
         fs_ff[2] <= 68'(st_in[SA+2].f2 * st_in[SA+2].f2);
      end
   end
   always_comb begin
      st_in[SA+3] = st_ff[SA+2];
      if (st_ff[SA+2].big) st_in[SA+3].ss = '1;
      else st_in[SA+3].ss = 100'(fs_ff[0]) + 100'(fs_ff[1]) + 100'(fs_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st_in[0];
         for (int i = 1; i < NST; i++) st_ff[i] <= st_in[i];
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_code = st_ff[NST-1].code;
   assign out_dist = (st_ff[NST-1].code == CASE_OUTSIDE) ? cfg.miss_value
                                                         : fold_q16(st_ff[NST-1].ss);
endmodule
`default_nettype wire

// ===== rtl/point_segment_distance_squared.sv =====
// Squared distance from a point to a 3D segment; front classifies, back computes.
// 23 register stages in all (2 front, 1 queue, 20 back); one item per cycle
// sustained, with stalls coming only from rsp_tready. The back pipeline
// (4-bit-per-stage divide) sets most of that depth.
// Synchronous active-high reset clears valids and loads register defaults.
`default_nettype none
module point_segment_distance_squared #(
   parameter int QueueDepth = psd_pkg::QueueDepth
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // point_x,y,z, seg_start_x,y,z, seg_end_x,y,z
   input wire logic [287:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // distance_sq
   output logic [47:0] rsp_tdata,
   // case_code
   output logic [1:0] rsp_tuser,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [2:0] csr_index,
   input wire logic [47:0] csr_data
);
   import psd_pkg::*;
   cfg_type cfg_ff;
   logic fv, fr, qv, qr;
   job_type fj, qj;
   case_type code;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length_sq <= 32'd65536;
         cfg_ff.z_tolerance <= 31'd1638;
         cfg_ff.t_lower <= -32'sd1638;
         cfg_ff.t_upper <= 32'sd98304;
         cfg_ff.miss_value <= 48'd65536000000;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MIN_LEN: cfg_ff.min_length_sq <= csr_data[31:0];
            REG_Z_TOL: cfg_ff.z_tolerance <= csr_data[30:0];
            REG_T_LOW: cfg_ff.t_lower <= csr_data[31:0];
            REG_T_UP: cfg_ff.t_upper <= csr_data[31:0];
            REG_MISS: cfg_ff.miss_value <= csr_data;
            default: ;
         endcase
      end
   end

   psd_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata), .cfg(cfg_ff), .out_valid(fv), .out_ready(fr), .out_job(fj));
   psd_queue #(.Depth(QueueDepth)) u_queue (.clock, .reset, .in_valid(fv),
      .in_ready(fr), .in_job(fj), .out_valid(qv), .out_ready(qr), .out_job(qj));
   psd_back u_back (.clock, .reset, .in_valid(qv), .in_ready(qr), .in_job(qj),
      .cfg(cfg_ff), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_dist(rsp_tdata), .out_code(code));
   assign rsp_tuser = code;
endmodule
`default_nettype wire

// ===== rtl/psd_checker.sv =====
// Port checker for the distance block, bound to the top level.
// Uses point_segment_distance_squared_defines.svh.
`include "point_segment_distance_squared_defines.svh"
`default_nettype none
module psd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic csr_ready
);
   `PSD_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `PSD_ASSERT_NXT(a_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `PSD_ASSERT_NXT(a_stable_code, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tuser))
   `PSD_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)
   `PSD_ASSERT_IMP(a_csr, clock, reset, 1'b1, csr_ready)
endmodule
bind point_segment_distance_squared psd_checker u_chk (.clock, .reset, .rsp_tvalid,
   .rsp_tready, .rsp_tdata, .rsp_tuser, .csr_ready);
`default_nettype wire
